/* rtl/rlsm_pkg.sv */
// package: types, constants and codes shared by the latency monitor
`default_nettype none
package rlsm_pkg;

  localparam int unsigned PendingEntriesDefault = 64;
  localparam int unsigned StatsEntriesDefault   = 64;
  localparam logic [31:0] SyncMaskReset         = 32'h0010_5000;
  localparam int unsigned SlotW                 = 6;

  // request type codes
  localparam logic [2:0] ReqWriteStart = 3'd0;
  localparam logic [2:0] ReqWriteEnd   = 3'd1;
  localparam logic [2:0] ReqFsyncStart = 3'd2;
  localparam logic [2:0] ReqFsyncEnd   = 3'd3;
  localparam logic [2:0] ReqReadSlot   = 3'd4;

  // result status codes
  localparam logic [2:0] StStarted     = 3'd0;
  localparam logic [2:0] StStartDrop   = 3'd1;
  localparam logic [2:0] StUpdated     = 3'd2;
  localparam logic [2:0] StNoMatch     = 3'd3;
  localparam logic [2:0] StErrDiscard  = 3'd4;
  localparam logic [2:0] StStatsFull   = 3'd5;
  localparam logic [2:0] StRead        = 3'd6;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [63:0]       thread_id;
    logic [63:0]       timestamp;
    logic [31:0]       file_flags;
    logic signed [63:0] return_value;
    logic [63:0]       name_low;
    logic [63:0]       name_high;
    logic [5:0]        read_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [31:0] pid;
    logic        sync_kind;
    logic [63:0] key_name_low;
    logic [63:0] key_name_high;
    logic [63:0] call_count;
    logic [63:0] byte_count;
    logic [63:0] latency_sum;
    logic [63:0] latency_max;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PSCAN,
    S_PDONE,
    S_SSCAN,
    S_SDONE,
    S_SREAD,
    S_SCALC,
    S_RREAD,
    S_RDONE,
    S_OUT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture request
    logic pscan_clr;   // restart pending scan
    logic pscan_step;  // examine one pending entry
    logic pwrite;      // write start into pending table
    logic pfree;       // clear pending valid of hit
    logic sscan_clr;
    logic sscan_step;
    logic sread;       // issue stats read at chosen slot
    logic swrite;      // write updated stats entry
    logic rread;       // issue stats read at read slot
    logic [2:0] status;
    logic set_out;     // load output register, entry fields if fill_entry
    logic fill_entry;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_read;
    logic pscan_last;
    logic phit;
    logic pfree_found;
    logic neg_ret;
    logic sscan_last;
    logic shit;
    logic sfree_found;
    logic rslot_live;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/rlsm_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module rlsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] addr_i,
  input  wire  [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/rlsm_ctrl.sv */
// controller state machine sequencing table scans and updates
`default_nettype none
module rlsm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  wire  rlsm_pkg::sts_t sts_i,
  output rlsm_pkg::cmd_t      cmd_o
);
  import rlsm_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PSCAN;
      S_PSCAN: begin
        if (sts_i.is_read) state_d = S_RREAD;
        else if (!sts_i.is_start && !sts_i.is_end) state_d = S_OUT;
        else if (sts_i.pscan_last) state_d = S_PDONE;
      end
      S_PDONE: begin
        if (sts_i.is_start || !sts_i.phit || sts_i.neg_ret) state_d = S_OUT;
        else state_d = S_SSCAN;
      end
      S_SSCAN: if (sts_i.sscan_last) state_d = S_SDONE;
      S_SDONE: begin
        if (!sts_i.shit && !sts_i.sfree_found) state_d = S_OUT;
        else state_d = S_SREAD;
      end
      S_SREAD: state_d = S_SCALC;
      S_SCALC: state_d = S_OUT;
      S_RREAD: state_d = S_RDONE;
      S_RDONE: state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: begin
        cmd_o.load      = in_valid_i;
        cmd_o.pscan_clr = 1'b1;
        cmd_o.sscan_clr = 1'b1;
      end
      S_PSCAN: begin
        cmd_o.pscan_step = sts_i.is_start || sts_i.is_end;
        if (!sts_i.is_read && !sts_i.is_start && !sts_i.is_end) begin
          cmd_o.set_out = 1'b1;
          cmd_o.status  = StNoMatch;
        end
      end
      S_PDONE: begin
        cmd_o.set_out = 1'b1;
        if (sts_i.is_start) begin
          if (sts_i.phit || sts_i.pfree_found) begin
            cmd_o.pwrite = 1'b1;
            cmd_o.status = StStarted;
          end else begin
            cmd_o.status = StStartDrop;
          end
        end else if (!sts_i.phit) begin
          cmd_o.status = StNoMatch;
        end else begin
          cmd_o.pfree = 1'b1;
          cmd_o.status = StErrDiscard;
          cmd_o.set_out = sts_i.neg_ret;
        end
      end
      S_SSCAN: cmd_o.sscan_step = 1'b1;
      S_SDONE: begin
        if (!sts_i.shit && !sts_i.sfree_found) begin
          cmd_o.set_out = 1'b1;
          cmd_o.status  = StStatsFull;
        end else begin
          cmd_o.sread = 1'b1;
        end
      end
      // selected slot is registered now, read it
      S_SREAD: cmd_o.sread = 1'b1;
      S_SCALC: begin
        cmd_o.swrite     = 1'b1;
        cmd_o.set_out    = 1'b1;
        cmd_o.fill_entry = 1'b1;
        cmd_o.status     = StUpdated;
      end
      S_RREAD: cmd_o.rread = 1'b1;
      S_RDONE: begin
        cmd_o.set_out    = 1'b1;
        cmd_o.fill_entry = sts_i.rslot_live;
        cmd_o.status     = StRead;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a new transaction is only taken when idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  // stats write only after a stats read
  a_swrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.swrite |-> $past(cmd_o.sread, 2)) else $error("write without read");
`endif
endmodule
`default_nettype wire

/* rtl/rlsm_dp.sv */
// datapath: in-flight table, stats table, scan counters and result register
`default_nettype none
module rlsm_dp #(
  parameter int unsigned PendingEntries = rlsm_pkg::PendingEntriesDefault,
  parameter int unsigned StatsEntries   = rlsm_pkg::StatsEntriesDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [31:0]         sync_mask_i,
  input  wire  rlsm_pkg::req_t req_i,
  input  wire  rlsm_pkg::cmd_t cmd_i,
  output rlsm_pkg::sts_t      sts_o,
  output rlsm_pkg::rsp_t      rsp_o
);
  import rlsm_pkg::*;

  localparam int unsigned PW = (PendingEntries > 1) ? $clog2(PendingEntries) : 1;
  localparam int unsigned SW = (StatsEntries > 1) ? $clog2(StatsEntries) : 1;
  localparam int unsigned PD = 1 << PW;
  localparam int unsigned SD = 1 << SW;
  localparam int unsigned KeyW = 32 + 1 + 128;
  localparam int unsigned CntW = 256;

  req_t req_q;
  rsp_t rsp_q, rsp_d;

  // capture request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  logic is_write_q;
  assign is_write_q = (req_q.req_type == ReqWriteStart) || (req_q.req_type == ReqWriteEnd);

  // ---------------- pending table
  logic [PendingEntries-1:0] pvalid_q;
  logic [PW:0]   pcnt_q;       // scan counter, one entry per cycle plus read latency
  logic          pchk_q;       // registered read data refers to pidx_q
  logic [PW-1:0] pidx_q;
  logic          phit_q, pfree_q;
  logic [PW-1:0] phit_idx_q, pfree_idx_q;
  logic [63:0]   pstart_q;
  logic          psync_q;
  logic [PW-1:0] paddr;
  logic          pwe;
  logic [128:0]  pwdata, prdata;

  assign pwe    = cmd_i.pwrite;
  assign paddr  = cmd_i.pwrite ? (phit_q ? phit_idx_q : pfree_idx_q) : pcnt_q[PW-1:0];
  assign pwdata = {req_q.thread_id, req_q.timestamp,
                   (req_q.req_type == ReqFsyncStart) ||
                   ((req_q.file_flags & sync_mask_i) != 32'd0)};

  rlsm_ram #(.Width(129), .Depth(PD)) u_pend (
    .clk_i, .we_i(pwe), .addr_i(paddr), .wdata_i(pwdata), .rdata_o(prdata)
  );

  logic pv_at;
  assign pv_at = (32'(pidx_q) < PendingEntries) ? pvalid_q[pidx_q] : 1'b0;

  // pending scan: address issued one cycle, compared the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0;
      pcnt_q   <= '0;
      pchk_q   <= 1'b0;
      phit_q   <= 1'b0;
      pfree_q  <= 1'b0;
    end else begin
      if (cmd_i.pscan_clr) begin
        pcnt_q  <= '0;
        pchk_q  <= 1'b0;
        phit_q  <= 1'b0;
        pfree_q <= 1'b0;
      end else if (cmd_i.pscan_step) begin
        if (32'(pcnt_q) < PendingEntries) pcnt_q <= pcnt_q + 1'b1;
        pchk_q <= (32'(pcnt_q) < PendingEntries);
        pidx_q <= pcnt_q[PW-1:0];
        if (pchk_q) begin
          if (pv_at) begin
            if (!phit_q && prdata[128:65] == req_q.thread_id) begin
              phit_q     <= 1'b1;
              phit_idx_q <= pidx_q;
              pstart_q   <= prdata[64:1];
              psync_q    <= prdata[0];
            end
          end else if (!pfree_q) begin
            pfree_q     <= 1'b1;
            pfree_idx_q <= pidx_q;
          end
        end
      end
      if (cmd_i.pwrite) pvalid_q[paddr] <= 1'b1;
      if (cmd_i.pfree)  pvalid_q[phit_idx_q] <= 1'b0;
    end
  end

  // ---------------- stats table
  logic [StatsEntries-1:0] svalid_q;
  logic [SW:0]   scnt_q;
  logic          schk_q;
  logic [SW-1:0] sidx_q;
  logic          shit_q, sfree_q;
  logic [SW-1:0] shit_idx_q, sfree_idx_q, sel_q;
  logic          snew_q;
  logic [SW-1:0] saddr;
  logic          swe;
  logic [KeyW-1:0] kwdata, krdata, key_cur;
  logic [CntW-1:0] cwdata, crdata;
  logic [63:0]   lat;
  logic [63:0]   c_calls, c_bytes, c_sum, c_max;

  assign key_cur = {req_q.thread_id[63:32], psync_q, req_q.name_low, req_q.name_high};
  assign lat     = req_q.timestamp - pstart_q;
  assign swe     = cmd_i.swrite;

  always_comb begin
    saddr = scnt_q[SW-1:0];
    if (cmd_i.sread || cmd_i.swrite) saddr = sel_q;
    else if (cmd_i.rread) saddr = req_q.read_slot[SW-1:0];
  end

  // new entry starts with zero counters
  assign c_calls = snew_q ? 64'd0 : crdata[255:192];
  assign c_bytes = snew_q ? 64'd0 : crdata[191:128];
  assign c_sum   = snew_q ? 64'd0 : crdata[127:64];
  assign c_max   = snew_q ? 64'd0 : crdata[63:0];

  logic [63:0] n_calls, n_bytes, n_sum, n_max;
  assign n_calls = c_calls + 64'd1;
  assign n_bytes = is_write_q ? c_bytes + req_q.return_value : c_bytes;
  assign n_sum   = c_sum + lat;
  assign n_max   = (lat > c_max) ? lat : c_max;
  assign kwdata  = key_cur;
  assign cwdata  = {n_calls, n_bytes, n_sum, n_max};

  rlsm_ram #(.Width(KeyW), .Depth(SD)) u_skey (
    .clk_i, .we_i(swe), .addr_i(saddr), .wdata_i(kwdata), .rdata_o(krdata)
  );
  rlsm_ram #(.Width(CntW), .Depth(SD)) u_scnt (
    .clk_i, .we_i(swe), .addr_i(saddr), .wdata_i(cwdata), .rdata_o(crdata)
  );

  logic sv_at;
  assign sv_at = (32'(sidx_q) < StatsEntries) ? svalid_q[sidx_q] : 1'b0;

  logic rlive;
  assign rlive = ({1'b0, req_q.read_slot} < (SlotW+1)'(StatsEntries > 64 ? 64 : StatsEntries))
                 && svalid_q[req_q.read_slot[SW-1:0]];

  // stats scan and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svalid_q <= '0;
      scnt_q   <= '0;
      schk_q   <= 1'b0;
      shit_q   <= 1'b0;
      sfree_q  <= 1'b0;
    end else begin
      if (cmd_i.sscan_clr) begin
        scnt_q  <= '0;
        schk_q  <= 1'b0;
        shit_q  <= 1'b0;
        sfree_q <= 1'b0;
      end else if (cmd_i.sscan_step) begin
        if (32'(scnt_q) < StatsEntries) scnt_q <= scnt_q + 1'b1;
        schk_q <= (32'(scnt_q) < StatsEntries);
        sidx_q <= scnt_q[SW-1:0];
        if (schk_q) begin
          if (sv_at) begin
            if (!shit_q && krdata == key_cur) begin
              shit_q     <= 1'b1;
              shit_idx_q <= sidx_q;
            end
          end else if (!sfree_q) begin
            sfree_q     <= 1'b1;
            sfree_idx_q <= sidx_q;
          end
        end
      end
      if (cmd_i.sread) begin
        sel_q  <= shit_q ? shit_idx_q : sfree_idx_q;
        snew_q <= !shit_q;
      end
      if (cmd_i.swrite) svalid_q[sel_q] <= 1'b1;
    end
  end

  // next result
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = cmd_i.status;
    if (cmd_i.status == StRead) rsp_d.slot = req_q.read_slot;
    if (cmd_i.fill_entry) begin
      rsp_d.entry_valid = 1'b1;
      if (cmd_i.status == StUpdated) begin
        rsp_d.slot          = SlotW'(sel_q);
        rsp_d.pid           = key_cur[160:129];
        rsp_d.sync_kind     = key_cur[128];
        rsp_d.key_name_low  = key_cur[127:64];
        rsp_d.key_name_high = key_cur[63:0];
        rsp_d.call_count    = n_calls;
        rsp_d.byte_count    = n_bytes;
        rsp_d.latency_sum   = n_sum;
        rsp_d.latency_max   = n_max;
      end else begin
        rsp_d.pid           = krdata[160:129];
        rsp_d.sync_kind     = krdata[128];
        rsp_d.key_name_low  = krdata[127:64];
        rsp_d.key_name_high = krdata[63:0];
        rsp_d.call_count    = crdata[255:192];
        rsp_d.byte_count    = crdata[191:128];
        rsp_d.latency_sum   = crdata[127:64];
        rsp_d.latency_max   = crdata[63:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_out) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  // status to controller
  always_comb begin
    sts_o             = '0;
    sts_o.is_start    = (req_q.req_type == ReqWriteStart) || (req_q.req_type == ReqFsyncStart);
    sts_o.is_end      = (req_q.req_type == ReqWriteEnd) || (req_q.req_type == ReqFsyncEnd);
    sts_o.is_read     = (req_q.req_type == ReqReadSlot);
    sts_o.pscan_last  = (32'(pcnt_q) >= PendingEntries) && !pchk_q;
    sts_o.phit        = phit_q;
    sts_o.pfree_found = pfree_q;
    sts_o.neg_ret     = req_q.return_value[63];
    sts_o.sscan_last  = (32'(scnt_q) >= StatsEntries) && !schk_q;
    sts_o.shit        = shit_q;
    sts_o.sfree_found = sfree_q;
    sts_o.rslot_live  = rlive;
  end

`ifndef NO_ASSERTIONS
  // a stats write never targets a live slot unless it was the matched key
  a_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.swrite && snew_q |-> !svalid_q[sel_q]) else $error("new entry over live slot");
  // a freed pending entry was live
  a_pfree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pfree |-> phit_q) else $error("free without hit");
  // a start writes only where it matched or found space
  a_pwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pwrite |-> phit_q || pfree_q) else $error("start write with full table");
`endif
endmodule
`default_nettype wire

/* rtl/request_latency_stats_monitor.sv */
// top level of the request latency statistics monitor
// Usage:
//  - request channel (in_valid_i / in_stall_o / in_data_i) carries one event
//    per transaction: write/fsync start or end, or a stats slot read.
//  - result channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//    one result per request transaction, in order.
//  - config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the sync
//    flag mask; always ready, write it only while idle.
//  - one request is handled at a time. A start or a request that fails the
//    in-flight lookup scans only the pending table, a completed end scans
//    the pending and then the stats table, and a read scans neither; the
//    scans walk the single-port tables entry by entry.
//  - reset clears all valid bits at once and loads the mask reset value; no
//    clearing pass is needed and the first request is taken right after.
//  - while the receiver stalls the result register holds and no new request
//    is taken.
`default_nettype none
module request_latency_stats_monitor #(
  parameter int unsigned PendingEntries = rlsm_pkg::PendingEntriesDefault,
  parameter int unsigned StatsEntries   = rlsm_pkg::StatsEntriesDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  rlsm_pkg::req_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output rlsm_pkg::rsp_t       out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [31:0]          cfg_data_i
);
  import rlsm_pkg::*;

  logic [31:0] mask_q;
  cmd_t cmd;
  sts_t sts;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= SyncMaskReset;
    end else if (cfg_valid_i) begin
      mask_q <= cfg_data_i;
    end
  end

  rlsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rlsm_dp #(.PendingEntries(PendingEntries), .StatsEntries(StatsEntries)) u_dp (
    .clk_i, .rst_ni, .sync_mask_i(mask_q), .req_i(in_data_i),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

`ifndef NO_ASSERTIONS
  // input accepted only while no result is pending
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o) else $error("overlapping transaction");
  // every accepted request leads to a result before the next is taken
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request too soon");
  // a result with a stall keeps its status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o.status)) else $error("status changed");
`endif
endmodule
`default_nettype wire

/* test/request_latency_stats_monitor_tb.sv */
// testbench for the request latency statistics monitor: random and directed events
`timescale 1ns / 100ps
module request_latency_stats_monitor_tb;
  import rlsm_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  request_latency_stats_monitor DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(req_valid), .in_stall_o(req_stall), .in_data_i(req_data),
    .out_valid_o(rsp_valid), .out_stall_i(rsp_stall), .out_data_o(rsp_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // in-flight and statistics tables of the predictor
  logic [31:0] mask_q;
  logic        flight_live [Depth];
  logic [63:0] flight_tid  [Depth];
  logic [63:0] flight_ts   [Depth];
  logic        flight_sync [Depth];
  logic        stat_live   [Depth];
  logic [31:0] stat_pid    [Depth];
  logic        stat_sync   [Depth];
  logic [63:0] stat_nlo    [Depth];
  logic [63:0] stat_nhi    [Depth];
  logic [63:0] stat_calls  [Depth];
  logic [63:0] stat_bytes  [Depth];
  logic [63:0] stat_lsum   [Depth];
  logic [63:0] stat_lmax   [Depth];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  logic failed = 1'b0;
  logic calm = 1'b0;
  int unsigned hold_req = 0;

  // thread and name pools used to build matching start/end pairs
  logic [63:0] tid_pool [12];
  logic [63:0] name_pool [4][2];

  function automatic rsp_t entry_of(logic [2:0] st, int s);
    rsp_t r;
    r = '0;
    r.status = st;
    r.slot = s[5:0];
    r.entry_valid = 1'b1;
    r.pid = stat_pid[s];
    r.sync_kind = stat_sync[s];
    r.key_name_low = stat_nlo[s];
    r.key_name_high = stat_nhi[s];
    r.call_count = stat_calls[s];
    r.byte_count = stat_bytes[s];
    r.latency_sum = stat_lsum[s];
    r.latency_max = stat_lmax[s];
    return r;
  endfunction

  // expected result of one request, updating the tables
  function automatic rsp_t predict_event(req_t q);
    rsp_t r;
    int hit, free_i, s;
    logic sync;
    logic [63:0] lat;
    r = '0;
    hit = -1;
    free_i = -1;
    s = -1;
    case (q.req_type)
      ReqWriteStart, ReqFsyncStart: begin
        sync = (q.req_type == ReqFsyncStart) || ((q.file_flags & mask_q) != 0);
        for (int i = 0; i < Depth; i++) begin
          if (flight_live[i]) begin
            if (hit < 0 && flight_tid[i] == q.thread_id) hit = i;
          end else if (free_i < 0) free_i = i;
        end
        if (hit < 0) hit = free_i;
        if (hit < 0) begin
          r.status = StStartDrop;
        end else begin
          flight_live[hit] = 1'b1;
          flight_tid[hit] = q.thread_id;
          flight_ts[hit] = q.timestamp;
          flight_sync[hit] = sync;
          r.status = StStarted;
        end
      end
      ReqWriteEnd, ReqFsyncEnd: begin
        for (int i = 0; i < Depth; i++)
          if (hit < 0 && flight_live[i] && flight_tid[i] == q.thread_id) hit = i;
        if (hit < 0) begin
          r.status = StNoMatch;
        end else begin
          flight_live[hit] = 1'b0;
          if (q.return_value[63]) begin
            r.status = StErrDiscard;
          end else begin
            lat = q.timestamp - flight_ts[hit];
            sync = flight_sync[hit];
            for (int i = 0; i < Depth; i++) begin
              if (stat_live[i]) begin
                if (s < 0 && stat_pid[i] == q.thread_id[63:32] && stat_sync[i] == sync &&
                    stat_nlo[i] == q.name_low && stat_nhi[i] == q.name_high) s = i;
              end else if (free_i < 0) free_i = i;
            end
            if (s < 0 && free_i >= 0) begin
              s = free_i;
              stat_live[s] = 1'b1;
              stat_pid[s] = q.thread_id[63:32];
              stat_sync[s] = sync;
              stat_nlo[s] = q.name_low;
              stat_nhi[s] = q.name_high;
              stat_calls[s] = '0;
              stat_bytes[s] = '0;
              stat_lsum[s] = '0;
              stat_lmax[s] = '0;
            end
            if (s < 0) begin
              r.status = StStatsFull;
            end else begin
              stat_calls[s] += 64'd1;
              if (q.req_type == ReqWriteEnd) stat_bytes[s] += q.return_value;
              stat_lsum[s] += lat;
              if (lat > stat_lmax[s]) stat_lmax[s] = lat;
              r = entry_of(StUpdated, s);
            end
          end
        end
      end
      ReqReadSlot: begin
        if (stat_live[q.read_slot]) begin
          r = entry_of(StRead, q.read_slot);
        end else begin
          r.status = StRead;
          r.slot = q.read_slot;
        end
      end
      default: r.status = StNoMatch;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(logic [2:0] kind, logic [63:0] tid);
    req_t q;
    q.req_type = kind;
    q.thread_id = tid;
    q.timestamp = rand64();
    q.file_flags = $urandom;
    q.return_value = rand64();
    q.name_low = rand64();
    q.name_high = rand64();
    q.read_slot = 6'($urandom_range(0, 63));
    return q;
  endfunction

  // mostly start/end pairs on a small thread pool, plus reads and noise
  function automatic req_t random_req();
    req_t q;
    int pick, nm;
    pick = $urandom_range(0, 99);
    nm = $urandom_range(0, 3);
    q = make_req(ReqWriteStart, tid_pool[$urandom_range(0, 11)]);
    if (pick < 20) q.req_type = ReqWriteStart;
    else if (pick < 35) q.req_type = ReqFsyncStart;
    else if (pick < 55) q.req_type = ReqWriteEnd;
    else if (pick < 70) q.req_type = ReqFsyncEnd;
    else if (pick < 82) q.req_type = ReqReadSlot;
    else if (pick < 88) q.req_type = 3'($urandom_range(5, 7));
    else begin
      q.req_type = $urandom_range(0, 1) ? ReqWriteEnd : ReqFsyncEnd;
      q.thread_id = rand64();
    end
    if (pick < 70) begin
      q.name_low = name_pool[nm][0];
      q.name_high = name_pool[nm][1];
      // errors now and then, otherwise small or huge byte counts
      case ($urandom_range(0, 5))
        0: q.return_value[63] = 1'b1;
        1: q.return_value[63] = 1'b0;
        default: q.return_value = 64'($urandom_range(0, 4096));
      endcase
    end
    return q;
  endfunction

  // driver: presents queued transactions at the falling edge
  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_gap = 0;
  int unsigned hold_cnt = 0;

  always @(negedge clk) begin
    logic nv;
    nv = req_valid;
    if (rst_n) begin
      if (req_valid && req_taken) begin
        nv = 1'b0;
        req_gap = calm ? 0 : $urandom_range(0, 6);
      end
      if (!nv) begin
        if (req_gap > 0) req_gap--;
        else if (pending_reqs.size() > 0) begin
          req_data <= pending_reqs.pop_front();
          nv = 1'b1;
        end
      end
      req_valid <= nv;
    end
  end

  // receiver: random stalls, and a long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (rsp_taken) rsp_gap = calm ? 0 : $urandom_range(0, 6);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    rsp_t e;
    req_taken <= req_valid && !req_stall;
    rsp_taken <= rsp_valid && !rsp_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mask_q <= cfg_data;
      if (req_valid && !req_stall) expected_rsps.push_back(predict_event(req_data));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no expectation: %p", rsp_data);
          failed <= 1'b1;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp_data != e) failed <= 1'b1;
          if (rsp_data.status != e.status)
            $error("status exp %0d got %0d", e.status, rsp_data.status);
          if (rsp_data.slot != e.slot)
            $error("slot exp %0d got %0d", e.slot, rsp_data.slot);
          if (rsp_data.entry_valid != e.entry_valid)
            $error("entry_valid exp %0d got %0d", e.entry_valid, rsp_data.entry_valid);
          if (rsp_data.pid != e.pid)
            $error("pid exp %h got %h", e.pid, rsp_data.pid);
          if (rsp_data.sync_kind != e.sync_kind)
            $error("sync_kind exp %0d got %0d", e.sync_kind, rsp_data.sync_kind);
          if (rsp_data.key_name_low != e.key_name_low)
            $error("key_name_low exp %h got %h", e.key_name_low, rsp_data.key_name_low);
          if (rsp_data.key_name_high != e.key_name_high)
            $error("key_name_high exp %h got %h", e.key_name_high, rsp_data.key_name_high);
          if (rsp_data.call_count != e.call_count)
            $error("call_count exp %h got %h", e.call_count, rsp_data.call_count);
          if (rsp_data.byte_count != e.byte_count)
            $error("byte_count exp %h got %h", e.byte_count, rsp_data.byte_count);
          if (rsp_data.latency_sum != e.latency_sum)
            $error("latency_sum exp %h got %h", e.latency_sum, rsp_data.latency_sum);
          if (rsp_data.latency_max != e.latency_max)
            $error("latency_max exp %h got %h", e.latency_max, rsp_data.latency_max);
        end
      end
    end
  end

  // watchdog: cycles without any transaction while work is outstanding
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (expected_rsps.size() == 0 && pending_reqs.size() == 0 && !req_valid)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("request_latency_stats_monitor_tb NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_mask(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random(int n);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  // stimulus
  initial begin
    req_t q;
    logic [63:0] ta, tb, tc;
    mask_q = SyncMaskReset;
    for (int i = 0; i < Depth; i++) begin
      flight_live[i] = 1'b0;
      stat_live[i] = 1'b0;
    end
    for (int i = 0; i < 12; i++)
      tid_pool[i] = {(i % 4 == 0) ? 32'h0 : (i % 4 == 1) ? 32'hFFFF_FFFF : $urandom, $urandom};
    name_pool[0][0] = '0; name_pool[0][1] = '0;
    name_pool[1][0] = '1; name_pool[1][1] = '1;
    for (int i = 2; i < 4; i++) begin
      name_pool[i][0] = rand64();
      name_pool[i][1] = rand64();
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty read, missing start, overwrite, wrap, errors, sync rules
    ta = tid_pool[0]; tb = tid_pool[1]; tc = tid_pool[2];
    q = make_req(ReqReadSlot, ta); q.read_slot = 0; pending_reqs.push_back(q);
    q = make_req(ReqWriteEnd, ta); pending_reqs.push_back(q);
    q = make_req(ReqWriteStart, ta); q.timestamp = '0; q.file_flags = 32'h1000;
    pending_reqs.push_back(q);
    q = make_req(ReqWriteStart, ta); q.timestamp = 64'd5; q.file_flags = '0;
    pending_reqs.push_back(q);
    q = make_req(ReqWriteEnd, ta); q.timestamp = '1; q.return_value = 64'd100;
    q.name_low = '0; q.name_high = '0; pending_reqs.push_back(q);
    q = make_req(ReqFsyncStart, tb); q.timestamp = '1; pending_reqs.push_back(q);
    q = make_req(ReqFsyncEnd, tb); q.timestamp = '0; q.return_value = 64'd7;
    pending_reqs.push_back(q);
    q = make_req(ReqWriteStart, tc); q.file_flags = '1; pending_reqs.push_back(q);
    q = make_req(ReqWriteEnd, tc); q.return_value = 64'h8000_0000_0000_0000;
    pending_reqs.push_back(q);
    q = make_req(ReqFsyncStart, ta); pending_reqs.push_back(q);
    q = make_req(ReqWriteEnd, ta); q.return_value = 64'h7FFF_FFFF_FFFF_FFFF;
    q.name_low = '0; q.name_high = '0; pending_reqs.push_back(q);
    q = make_req(ReqWriteStart, tc); q.file_flags = '0; pending_reqs.push_back(q);
    q = make_req(ReqFsyncEnd, tc); q.return_value = '1; pending_reqs.push_back(q);
    for (int k = 5; k < 8; k++) pending_reqs.push_back(make_req(3'(k), ta));
    for (int k = 0; k < 3; k++) begin
      q = make_req(ReqReadSlot, ta);
      q.read_slot = (k == 2) ? 6'd63 : 6'(k);
      pending_reqs.push_back(q);
    end
    wait_drained();

    write_mask('0);
    add_random(400);
    wait_drained();

    // all-ones mask, receiver holds off while requests pile up
    write_mask('1);
    add_random(400);
    hold_req = HoldCycles;
    wait_drained();

    // fill the in-flight table, overflow it, then discard every entry
    calm = 1'b1;
    tc = rand64();
    for (int i = 0; i <= Depth; i++) begin
      q = make_req(ReqFsyncStart, {tc[63:32], 32'(i)});
      pending_reqs.push_back(q);
    end
    for (int i = 0; i <= Depth; i++) begin
      q = make_req(ReqWriteEnd, {tc[63:32], 32'(i)});
      q.return_value[63] = 1'b1;
      pending_reqs.push_back(q);
    end
    wait_drained();
    calm = 1'b0;

    write_mask($urandom);
    add_random(400);
    wait_drained();

    // back to the reset mask, then fill the statistics table until full
    write_mask(SyncMaskReset);
    for (int i = 0; i < Depth + 4; i++) begin
      tc = rand64();
      q = make_req(ReqFsyncStart, tc);
      pending_reqs.push_back(q);
      q = make_req(ReqFsyncEnd, tc);
      q.return_value[63] = 1'b0;
      pending_reqs.push_back(q);
    end
    add_random(60);
    wait_drained();

    if (failed) $display("request_latency_stats_monitor_tb NOT OK");
    else $display("request_latency_stats_monitor_tb OK");
    $finish;
  end
endmodule
